@@ rtl/edib_pkg.sv @@
// Shared types and constants for the element DOF inverse index builder.
// Used by the top level; no dependencies.
`default_nettype none

package edib_pkg;

	// Fixed field widths of the stream and configuration ports
	localparam int CMD_W      = 3;
	localparam int POS_W      = 14;
	localparam int VAL_W      = 10;
	localparam int STAT_W     = 2;
	localparam int DATA_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int GCNT_W     = 11;
	localparam int LCNT_W     = 7;
	localparam int ECNT_W     = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_PERM = 3'd0,
		CMD_LOAD_ELEM = 3'd1,
		CMD_BUILD     = 3'd2,
		CMD_READ_OFS  = 3'd3,
		CMD_READ_IDX  = 3'd4,
		CMD_READ_MAP  = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_VALUE = 2'd1,
		STAT_POS   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GCOUNT = 3'd0,
		REG_LCOUNT = 3'd1,
		REG_ECOUNT = 3'd2,
		REG_IDENT  = 3'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_BSTART,
		ST_CHK_PERM,
		ST_CHK_ELEM,
		ST_CLEAR,
		ST_W_PERM,
		ST_W_ELEM,
		ST_W_OFS,
		ST_W_WR,
		ST_PFX_RD,
		ST_PFX_WR
	} state_t;

endpackage

`default_nettype wire

@@ rtl/edib_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module edib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/element_dof_inverse_index_builder_core.sv @@
// Top level of the element DOF inverse index builder (counting-sort CSR transpose).
// Depends on edib_pkg and edib_ram.
//
// Usage:
//   s_* stream carries commands: tuser = command, tdata = {value, position}.
//   m_* stream returns one result per command: tuser = status, tdata = read data.
//   cfg_* channel writes the four size/mode registers; write only while idle.
// Result path and throughput:
//   Load commands and out-of-range reads: result valid in the cycle after the transfer.
//   In-range reads: result passes through the registered RAM read, then the output register.
//   Loads and out-of-range reads are taken one per cycle while results are
//   drained; an in-range read holds off input until its result is registered.
//   Build: every slot does a permutation read, element read and offset
//   read-modify-write, once for counting and once for scattering. Input is
//   held off for the whole build.
// Reset: registers return to defaults, nothing is built, no RAM clearing pass;
//   the offset table is cleared by each build before use.
// Stall: a held result keeps the output register; a new command is taken only
//   when that register is free or being drained in the same cycle.
`default_nettype none

module element_dof_inverse_index_builder_core #(
	parameter int MAX_GLOBAL  = 1024,
	parameter int MAX_LOCAL   = 64,
	parameter int MAX_ENTRIES = 16384
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	// command stream
	input  wire logic                                               s_tvalid,
	output logic                                                    s_tready,
	input  wire logic [edib_pkg::POS_W+edib_pkg::VAL_W-1:0]         s_tdata, // position, value
	input  wire logic [edib_pkg::CMD_W-1:0]                         s_tuser, // command
	// result stream
	output logic                                                    m_tvalid,
	input  wire logic                                               m_tready,
	output logic      [15:0]                                        m_tdata, // read_data, zero pad
	output logic      [edib_pkg::STAT_W-1:0]                        m_tuser, // status
	// configuration writes
	input  wire logic                                               cfg_valid,
	output logic                                                    cfg_ready,
	input  wire logic [edib_pkg::CFG_IDX_W-1:0]                     cfg_index,
	input  wire logic [edib_pkg::CFG_DATA_W-1:0]                    cfg_data
);

	import edib_pkg::*;

	localparam int PAW = (MAX_LOCAL > 1) ? $clog2(MAX_LOCAL) : 1;
	localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int GW  = $clog2(MAX_GLOBAL);
	localparam int GAW = $clog2(MAX_GLOBAL + 1);
	localparam int OW  = $clog2(MAX_ENTRIES + 1);
	localparam int LCW = $clog2(MAX_LOCAL + 1);
	localparam int NW  = LCW + ECNT_W;
	localparam int CW  = (OW > GAW) ? OW : GAW;

	// configuration registers
	logic [GCNT_W-1:0] gcount_q;
	logic [LCNT_W-1:0] lcount_q;
	logic [ECNT_W-1:0] ecount_q;
	logic              ident_q;

	// control and build state
	state_t          state_q, state_d;
	cmd_t            rsel_q;
	logic [GAW-1:0]  gc_q, bglob_q;
	logic [LCW-1:0]  lc_q;
	logic [ECNT_W-1:0] ec_q, e_q;
	logic [NW-1:0]   n_q;
	logic [OW-1:0]   bent_q, acc_q;
	logic [CW-1:0]   cnt_q;
	logic            chk_v_s1, err_q, pass_q;
	logic [PAW-1:0]  d_q;
	logic [AW-1:0]   base_q;
	logic [GW-1:0]   g_q;
	logic [GAW-1:0]  ofs_addr_q;

	// output register
	logic            m_tvalid_q;
	status_t         stat_q;
	logic [DATA_W-1:0] rdata_q;

	// RAM ports
	logic            perm_we, elem_we, ofs_we, idx_we, gos_we;
	logic [PAW-1:0]  perm_waddr, perm_raddr, perm_wdata, perm_rdata;
	logic [AW-1:0]   elem_waddr, elem_raddr;
	logic [GW-1:0]   elem_wdata, elem_rdata;
	logic [GAW-1:0]  ofs_waddr, ofs_raddr;
	logic [OW-1:0]   ofs_wdata, ofs_rdata;
	logic [AW-1:0]   idx_waddr, idx_raddr, idx_wdata, idx_rdata;
	logic [AW-1:0]   gos_waddr, gos_raddr;
	logic [GW-1:0]   gos_wdata, gos_rdata;

	// decoded input and helpers
	cmd_t            cmd;
	logic [POS_W-1:0] pos;
	logic [VAL_W-1:0] val;
	logic            acc;
	logic [GAW-1:0]  eff_gc;
	logic [LCW-1:0]  eff_lc;
	logic [ECNT_W-1:0] eff_ec;
	logic            out_set;
	status_t         out_stat;
	logic [DATA_W-1:0] out_data;
	logic            issue, last_slot, last_elem;
	logic [AW-1:0]   slot;
	logic [PAW-1:0]  src;
	logic [OW-1:0]   pfx_sum;

	assign cmd       = cmd_t'(s_tuser);
	assign pos       = s_tdata[POS_W-1:0];
	assign val       = s_tdata[POS_W +: VAL_W];
	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign acc       = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = stat_q;
	assign m_tdata   = 16'(rdata_q);

	// effective sizes with out-of-range register values clamped
	always_comb begin
		if (gcount_q == '0) eff_gc = GAW'(1);
		else if (32'(gcount_q) > MAX_GLOBAL) eff_gc = GAW'(MAX_GLOBAL);
		else eff_gc = GAW'(gcount_q);
		if (lcount_q == '0) eff_lc = LCW'(1);
		else if (32'(lcount_q) > MAX_LOCAL) eff_lc = LCW'(MAX_LOCAL);
		else eff_lc = LCW'(lcount_q);
		eff_ec = (ecount_q == '0) ? ECNT_W'(1) : ecount_q;
	end

	// walk helpers
	assign src       = ident_q ? d_q : perm_rdata;
	assign slot      = AW'(base_q + AW'(d_q));
	assign last_elem = (32'(e_q) + 1) == 32'(ec_q);
	assign last_slot = ((32'(d_q) + 1) == 32'(lc_q)) && last_elem;
	assign pfx_sum   = OW'(acc_q + ofs_rdata);
	always_comb begin
		case (state_q)
			ST_CHK_PERM: issue = 32'(cnt_q) < 32'(lc_q);
			ST_CHK_ELEM: issue = 32'(cnt_q) < 32'(n_q);
			default:     issue = 1'b0;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcount_q <= GCNT_W'(1);
			lcount_q <= LCNT_W'(1);
			ecount_q <= ECNT_W'(1);
			ident_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_GCOUNT: gcount_q <= cfg_data[GCNT_W-1:0];
				REG_LCOUNT: lcount_q <= cfg_data[LCNT_W-1:0];
				REG_ECOUNT: ecount_q <= cfg_data[ECNT_W-1:0];
				REG_IDENT:  ident_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_BUILD: state_d = ST_BSTART;
						CMD_READ_OFS:
							if (32'(pos) <= 32'(bglob_q) && pos != '0) state_d = ST_READ;
						CMD_READ_IDX, CMD_READ_MAP:
							if (32'(pos) < 32'(bent_q)) state_d = ST_READ;
						default: ;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_BSTART: begin
				if (32'(n_q) > MAX_ENTRIES) state_d = ST_IDLE;
				else if (!ident_q) state_d = ST_CHK_PERM;
				else state_d = ST_CHK_ELEM;
			end
			ST_CHK_PERM:
				if (!issue && !chk_v_s1) state_d = err_q ? ST_IDLE : ST_CHK_ELEM;
			ST_CHK_ELEM:
				if (!issue && !chk_v_s1) state_d = err_q ? ST_IDLE : ST_CLEAR;
			ST_CLEAR:
				if (32'(cnt_q) == 32'(gc_q)) state_d = ST_W_PERM;
			ST_W_PERM: state_d = ST_W_ELEM;
			ST_W_ELEM: state_d = ST_W_OFS;
			ST_W_OFS:  state_d = ST_W_WR;
			ST_W_WR: begin
				if (!last_slot) state_d = ST_W_PERM;
				else if (!pass_q) state_d = ST_PFX_RD;
				else state_d = ST_IDLE;
			end
			ST_PFX_RD: state_d = ST_PFX_WR;
			ST_PFX_WR:
				state_d = (32'(cnt_q) == 32'(gc_q)) ? ST_W_PERM : ST_PFX_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls and result
	always_comb begin
		perm_we = 1'b0; perm_waddr = PAW'(pos); perm_wdata = PAW'(val);
		elem_we = 1'b0; elem_waddr = AW'(pos);  elem_wdata = GW'(val);
		ofs_we = 1'b0;  ofs_waddr = ofs_addr_q; ofs_wdata = '0;
		idx_we = 1'b0;  idx_waddr = AW'(ofs_rdata); idx_wdata = slot;
		gos_we = 1'b0;  gos_waddr = slot; gos_wdata = g_q;
		perm_raddr = d_q;
		elem_raddr = AW'(base_q + AW'(src));
		ofs_raddr  = GAW'(pos - 1'b1);
		idx_raddr  = AW'(pos);
		gos_raddr  = AW'(pos);
		out_set = 1'b0; out_stat = STAT_OK; out_data = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_LOAD_PERM: begin
							out_set = 1'b1;
							if (32'(pos) >= MAX_LOCAL) out_stat = STAT_POS;
							else if (32'(val) >= 32'(eff_lc)) out_stat = STAT_VALUE;
							else perm_we = 1'b1;
						end
						CMD_LOAD_ELEM: begin
							out_set = 1'b1;
							if (32'(pos) >= MAX_ENTRIES) out_stat = STAT_POS;
							else if (32'(val) >= 32'(eff_gc)) out_stat = STAT_VALUE;
							else elem_we = 1'b1;
						end
						CMD_BUILD: ;
						CMD_READ_OFS: begin
							if (32'(pos) > 32'(bglob_q)) begin
								out_set = 1'b1; out_stat = STAT_POS;
							end else if (pos == '0) begin
								out_set = 1'b1;
							end
						end
						CMD_READ_IDX, CMD_READ_MAP: begin
							if (32'(pos) >= 32'(bent_q)) begin
								out_set = 1'b1; out_stat = STAT_POS;
							end
						end
						default: out_set = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				out_set = 1'b1;
				case (rsel_q)
					CMD_READ_OFS: out_data = DATA_W'(ofs_rdata);
					CMD_READ_IDX: out_data = DATA_W'(idx_rdata);
					default:      out_data = DATA_W'(gos_rdata);
				endcase
			end
			ST_BSTART: begin
				if (32'(n_q) > MAX_ENTRIES) begin
					out_set = 1'b1; out_stat = STAT_POS;
				end
			end
			ST_CHK_PERM: begin
				perm_raddr = PAW'(cnt_q);
				if (!issue && !chk_v_s1 && err_q) begin
					out_set = 1'b1; out_stat = STAT_VALUE;
				end
			end
			ST_CHK_ELEM: begin
				elem_raddr = AW'(cnt_q);
				if (!issue && !chk_v_s1 && err_q) begin
					out_set = 1'b1; out_stat = STAT_VALUE;
				end
			end
			ST_CLEAR: begin
				ofs_we = 1'b1; ofs_waddr = GAW'(cnt_q);
			end
			ST_W_OFS: begin
				ofs_raddr = pass_q ? GAW'(elem_rdata) : GAW'(elem_rdata) + GAW'(1);
			end
			ST_W_WR: begin
				ofs_we = 1'b1; ofs_wdata = OW'(ofs_rdata + 1'b1);
				idx_we = pass_q;
				gos_we = pass_q;
				if (last_slot && pass_q) out_set = 1'b1;
			end
			ST_PFX_RD: ofs_raddr = GAW'(cnt_q);
			ST_PFX_WR: begin
				ofs_we = 1'b1; ofs_waddr = GAW'(cnt_q); ofs_wdata = pfx_sum;
			end
			default: ;
		endcase
	end

	// state, build counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			bglob_q    <= '0;
			bent_q     <= '0;
			chk_v_s1   <= 1'b0;
			err_q      <= 1'b0;
			pass_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_set) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			chk_v_s1 <= issue;
			case (state_q)
				ST_BSTART: begin
					err_q <= 1'b0;
				end
				ST_CHK_PERM:
					if (chk_v_s1 && 32'(perm_rdata) >= 32'(lc_q)) err_q <= 1'b1;
				ST_CHK_ELEM:
					if (chk_v_s1 && 32'(elem_rdata) >= 32'(gc_q)) err_q <= 1'b1;
				ST_CLEAR: pass_q <= 1'b0;
				ST_PFX_WR: pass_q <= 1'b1;
				ST_W_WR:
					if (last_slot && pass_q) begin
						bglob_q <= gc_q;
						bent_q  <= OW'(n_q);
					end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_set) begin
			stat_q  <= out_stat;
			rdata_q <= out_data;
		end
		case (state_q)
			ST_IDLE: begin
				rsel_q <= cmd;
				gc_q   <= eff_gc;
				lc_q   <= eff_lc;
				ec_q   <= eff_ec;
				n_q    <= NW'(eff_lc * eff_ec);
			end
			ST_BSTART: cnt_q <= '0;
			ST_CHK_PERM, ST_CHK_ELEM: begin
				if (issue) cnt_q <= CW'(cnt_q + 1'b1);
				else if (!chk_v_s1) cnt_q <= '0;
			end
			ST_CLEAR: begin
				cnt_q  <= CW'(cnt_q + 1'b1);
				d_q    <= '0;
				e_q    <= '0;
				base_q <= '0;
			end
			ST_W_OFS: begin
				g_q        <= elem_rdata;
				ofs_addr_q <= ofs_raddr;
			end
			ST_W_WR: begin
				if (32'(d_q) + 1 == 32'(lc_q)) begin
					d_q    <= '0;
					e_q    <= ECNT_W'(e_q + 1'b1);
					base_q <= AW'(base_q + AW'(lc_q));
				end else begin
					d_q <= PAW'(d_q + 1'b1);
				end
				if (last_slot) begin
					cnt_q <= CW'(1);
					acc_q <= '0;
				end
			end
			ST_PFX_WR: begin
				acc_q  <= pfx_sum;
				cnt_q  <= CW'(cnt_q + 1'b1);
				d_q    <= '0;
				e_q    <= '0;
				base_q <= '0;
			end
			default: ;
		endcase
	end

	// table storage
	edib_ram #(.WIDTH(PAW), .DEPTH(MAX_LOCAL)) u_perm (
		.clk(clk), .we(perm_we), .waddr(perm_waddr), .wdata(perm_wdata),
		.raddr(perm_raddr), .rdata(perm_rdata)
	);
	edib_ram #(.WIDTH(GW), .DEPTH(MAX_ENTRIES)) u_elem (
		.clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(elem_wdata),
		.raddr(elem_raddr), .rdata(elem_rdata)
	);
	edib_ram #(.WIDTH(OW), .DEPTH(MAX_GLOBAL + 1)) u_ofs (
		.clk(clk), .we(ofs_we), .waddr(ofs_waddr), .wdata(ofs_wdata),
		.raddr(ofs_raddr), .rdata(ofs_rdata)
	);
	edib_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_idx (
		.clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
		.raddr(idx_raddr), .rdata(idx_rdata)
	);
	edib_ram #(.WIDTH(GW), .DEPTH(MAX_ENTRIES)) u_gos (
		.clk(clk), .we(gos_we), .waddr(gos_waddr), .wdata(gos_wdata),
		.raddr(gos_raddr), .rdata(gos_rdata)
	);

	// checks
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (!m_tvalid_q || m_tready))
		else $error("command taken while a result is stuck");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input ready during build or read");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> m_tvalid_q)
		else $error("read did not produce a result");
	a_ofs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ofs_we |-> (32'(ofs_waddr) <= 32'(gc_q)))
		else $error("offset write beyond DOF count");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for element_dof_inverse_index_builder_core.
// Drives load, build and read commands with random gaps and checks every result
// against an in-file prediction of the counting-sort transpose. Depends on edib_pkg.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import edib_pkg::*;

	localparam int NGLOB = 1024;
	localparam int NLOC  = 64;
	localparam int NENT  = 16384;
	// command codes the block does not define; it must answer them with OK
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} cmd_item_t;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] data;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [POS_W+VAL_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	element_dof_inverse_index_builder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predicted block state
	logic [GCNT_W-1:0] gcount_r;
	logic [LCNT_W-1:0] lcount_r;
	logic [ECNT_W-1:0] ecount_r;
	logic              ident_r;
	logic [5:0]        perm_mem[NLOC];
	logic [VAL_W-1:0]  elem_mem[NENT];
	int                ofs_mem[NGLOB+1];
	int                idx_mem[NENT];
	int                dof_of_slot[NENT];
	int                built_dofs;
	int                built_slots;

	cmd_item_t pend_q[$];
	outcome_t  result_q[$];
	int        errors;
	int        n_items;

	function automatic int eff_global();
		if (gcount_r == 0) return 1;
		return (gcount_r > NGLOB) ? NGLOB : int'(gcount_r);
	endfunction

	function automatic int eff_local();
		if (lcount_r == 0) return 1;
		return (lcount_r > NLOC) ? NLOC : int'(lcount_r);
	endfunction

	function automatic int eff_elems();
		return (ecount_r == 0) ? 1 : int'(ecount_r);
	endfunction

	function automatic int dof_at(int e, int d, int lc);
		int src;
		src = ident_r ? d : int'(perm_mem[d]);
		return int'(elem_mem[lc*e + src]);
	endfunction

	// Counting sort: count per DOF, prefix sum, scatter, shift back
	function automatic logic [STAT_W-1:0] build_inverse();
		int gc, lc, ec, n, g, slot;
		gc = eff_global();
		lc = eff_local();
		ec = eff_elems();
		n = lc * ec;
		if (n > NENT) return STAT_POS;
		if (!ident_r)
			for (int d = 0; d < lc; d++)
				if (perm_mem[d] >= lc) return STAT_VALUE;
		for (int i = 0; i < n; i++)
			if (elem_mem[i] >= gc) return STAT_VALUE;
		for (int i = 0; i <= gc; i++) ofs_mem[i] = 0;
		for (int e = 0; e < ec; e++)
			for (int d = 0; d < lc; d++)
				ofs_mem[dof_at(e, d, lc) + 1]++;
		for (int i = 1; i <= gc; i++) ofs_mem[i] += ofs_mem[i-1];
		for (int e = 0; e < ec; e++) begin
			for (int d = 0; d < lc; d++) begin
				g = dof_at(e, d, lc);
				slot = lc*e + d;
				idx_mem[ofs_mem[g]] = slot;
				ofs_mem[g]++;
				dof_of_slot[slot] = g;
			end
		end
		for (int i = gc; i > 0; i--) ofs_mem[i] = ofs_mem[i-1];
		ofs_mem[0] = 0;
		built_dofs = gc;
		built_slots = n;
		return STAT_OK;
	endfunction

	function automatic outcome_t apply_command(cmd_item_t it);
		outcome_t r;
		r.status = STAT_OK;
		r.data = '0;
		case (it.cmd)
			CMD_LOAD_PERM: begin
				if (it.pos >= NLOC) r.status = STAT_POS;
				else if (it.val >= eff_local()) r.status = STAT_VALUE;
				else perm_mem[it.pos[5:0]] = it.val[5:0];
			end
			CMD_LOAD_ELEM: begin
				if (it.val >= eff_global()) r.status = STAT_VALUE;
				else elem_mem[it.pos] = it.val;
			end
			CMD_BUILD: r.status = build_inverse();
			CMD_READ_OFS: begin
				if (it.pos > built_dofs) r.status = STAT_POS;
				else r.data = DATA_W'(ofs_mem[it.pos[10:0]]);
			end
			CMD_READ_IDX: begin
				if (it.pos >= built_slots) r.status = STAT_POS;
				else r.data = DATA_W'(idx_mem[it.pos]);
			end
			CMD_READ_MAP: begin
				if (it.pos >= built_slots) r.status = STAT_POS;
				else r.data = DATA_W'(dof_of_slot[it.pos]);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Command driver: bursts of random length separated by random gaps
	cmd_item_t cur_cmd;
	logic      drv_busy;
	int        burst_left;
	int        gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			drv_busy = 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				result_q.push_back(apply_command(cur_cmd));
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur_cmd = pend_q.pop_front();
					drv_busy = 1'b1;
					s_tvalid <= 1'b1;
					s_tdata <= {cur_cmd.val, cur_cmd.pos};
					s_tuser <= cur_cmd.cmd;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor; ready follows a random stall mode: always ready, ready at random, or rarely ready
	int stall_mode;
	int mode_left;
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode = 0;
			mode_left = 100;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report($sformatf("unexpected result status %0d data %0d", m_tuser, m_tdata));
				end else begin
					want = result_q.pop_front();
					if (m_tuser !== want.status)
						report($sformatf("status %0d, expected %0d", m_tuser, want.status));
					if (m_tdata !== {1'b0, want.data})
						report($sformatf("read_data %0d, expected %0d", m_tdata, want.data));
				end
			end
			if (--mode_left <= 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 300);
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	task automatic put(input logic [CMD_W-1:0] cmd, input int pos, input int val);
		cmd_item_t it;
		it.cmd = cmd;
		it.pos = pos[POS_W-1:0];
		it.val = val[VAL_W-1:0];
		pend_q.push_back(it);
		n_items++;
	endtask

	// Wait until every transfer has produced its result, plus a margin
	task automatic drain();
		while (pend_q.size() != 0 || drv_busy || result_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input int value);
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GCOUNT: gcount_r = value[GCNT_W-1:0];
			REG_LCOUNT: lcount_r = value[LCNT_W-1:0];
			REG_ECOUNT: ecount_r = value[ECNT_W-1:0];
			default:    ident_r = value[0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int g, input int l, input int e, input int ident);
		cfg_write(REG_GCOUNT, g);
		cfg_write(REG_LCOUNT, l);
		cfg_write(REG_ECOUNT, e);
		cfg_write(REG_IDENT, ident);
	endtask

	// A command with random fields, used as noise between well-formed sequences
	task automatic put_noise();
		logic [CMD_W-1:0] c;
		c = CMD_W'($urandom_range(0, 7));
		// a build here could walk entries that were never loaded
		if (c == CMD_BUILD) c = CMD_SPARE_LO;
		put(c, $urandom_range(0, NENT-1), $urandom_range(0, 1023));
	endtask

	// One well-formed sequence: fill every used entry, usually build, read back
	task automatic random_phase();
		int g, l, e, n, ident, nread;
		g = ($urandom_range(0, 5) == 0) ? NGLOB : $urandom_range(1, 16);
		l = $urandom_range(1, 8);
		e = $urandom_range(1, 8);
		if ($urandom_range(0, 7) == 0) begin
			l = 1;
			e = $urandom_range(20, 64);
		end
		ident = $urandom_range(0, 1);
		n = l * e;
		drain();
		configure(g, l, e, ident);
		if (!ident)
			for (int d = 0; d < l; d++) put(CMD_LOAD_PERM, d, $urandom_range(0, l-1));
		for (int i = 0; i < n; i++) begin
			put(CMD_LOAD_ELEM, i, $urandom_range(0, g-1));
			if ($urandom_range(0, 9) == 0) put_noise();
		end
		// now and then leave out the build so reads see older tables
		if ($urandom_range(0, 9) != 0) put(CMD_BUILD, 0, $urandom_range(0, 1023));
		nread = $urandom_range(4, 16);
		for (int i = 0; i < nread; i++) begin
			case ($urandom_range(0, 3))
				0: put(CMD_READ_OFS, $urandom_range(0, g+2), $urandom_range(0, 1023));
				1: put(CMD_READ_IDX, $urandom_range(0, n+2), $urandom_range(0, 1023));
				2: put(CMD_READ_MAP, $urandom_range(0, n+2), $urandom_range(0, 1023));
				default: put_noise();
			endcase
		end
	endtask

	initial begin
		errors = 0;
		n_items = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gcount_r = 1;
		lcount_r = 1;
		ecount_r = 1;
		ident_r = 1'b1;
		built_dofs = 0;
		built_slots = 0;
		for (int i = 0; i <= NGLOB; i++) ofs_mem[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset: nothing built, unknown commands, load range errors
		put(CMD_READ_OFS, 0, 0);
		put(CMD_READ_OFS, 1, 0);
		put(CMD_READ_IDX, 0, 0);
		put(CMD_READ_MAP, NENT-1, 0);
		put(CMD_SPARE_LO, NENT-1, 1023);
		put(CMD_SPARE_HI, 0, 0);
		put(CMD_LOAD_PERM, NLOC, 0);
		put(CMD_LOAD_PERM, 0, 1);
		put(CMD_LOAD_ELEM, NENT-1, 0);
		put(CMD_LOAD_ELEM, 0, 1023);
		put(CMD_LOAD_ELEM, 0, 0);
		put(CMD_BUILD, 0, 0);
		put(CMD_READ_OFS, 1, 0);
		put(CMD_READ_IDX, 0, 0);
		put(CMD_READ_MAP, 0, 0);
		drain();

		// Upper extremes: counts clamp, too many entries for the table
		configure(2047, 127, 511, 0);
		put(CMD_LOAD_ELEM, NENT-1, 1023);
		put(CMD_LOAD_PERM, NLOC-1, 63);
		put(CMD_BUILD, 0, 0);
		drain();

		// Zero counts behave as one
		configure(0, 0, 0, 0);
		put(CMD_LOAD_PERM, 0, 0);
		put(CMD_BUILD, 0, 0);
		put(CMD_READ_OFS, 1, 0);
		put(CMD_READ_OFS, 2, 0);
		drain();

		// Build refused: permutation entry beyond a shrunken local count
		configure(8, 4, 2, 0);
		for (int d = 0; d < 4; d++) put(CMD_LOAD_PERM, d, 3 - d);
		for (int i = 0; i < 8; i++) put(CMD_LOAD_ELEM, i, 7 - i);
		drain();
		cfg_write(REG_LCOUNT, 3);
		put(CMD_BUILD, 0, 0);
		drain();
		// Build refused: element entry beyond a shrunken DOF count
		configure(4, 4, 2, 0);
		put(CMD_BUILD, 0, 0);
		put(CMD_READ_OFS, 4, 0);
		drain();

		while (n_items < 450) random_phase();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
